/* sv/box_blur_3x3_rgb_macros.svh */
// Assertion macros for the box blur block.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bblur_pkg.sv */
// Types, constants and helper functions for the 3x3 RGB box blur.
package bblur_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int SUM_W      = CH_W + 4;
	localparam int CNT_W      = 4;
	localparam int RCP_W      = 18;
	localparam int RCP_SHIFT  = 18;
	localparam int PROD_W     = SUM_W + 1 + RCP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            frame_last;
	} blur_t;

	// per-item control carried down the pipe
	typedef struct packed {
		logic do_out;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} ctl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

	// ceil(2^18 / (2n)) for the neighbor counts that can occur
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			CNT_W'(1): r = RCP_W'(131072);
			CNT_W'(2): r = RCP_W'(65536);
			CNT_W'(3): r = RCP_W'(43691);
			CNT_W'(4): r = RCP_W'(32768);
			CNT_W'(6): r = RCP_W'(21846);
			CNT_W'(9): r = RCP_W'(14564);
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

/* sv/box_blur_3x3_rgb.sv */
// 3x3 RGB box blur over a raster pixel stream, line buffer in one RAM.
//
//  channel  signals                          direction  payload
//  pix      pix_valid, pix_stall, pix        in         pix_t: op, red/green/blue_in
//  blur     blur_valid, blur_stall, blur     out        blur_t: channels, frame_last
//  cfg      cfg_wr_en, cfg_index, cfg_data   in         image_width, image_height
//
// One transaction per cycle sustained while blur_stall stays low; a result is valid once the transaction
// that completes its window (width+1 transactions after its own pixel) has passed the
// line RAM read, window update, sum register and multiply into the output reg.
// The line RAM (both line rows in one 48-bit word) is read and rewritten once
// per pixel; back-to-back hits on the same column are forwarded.
// Reset clears counters, window and valids; RAM contents need no clearing.
// pix_stall rises only when every stage back to the RAM read is held.
`include "box_blur_3x3_rgb_macros.svh"

module box_blur_3x3_rgb
	import bblur_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_t                  pix,
	output logic                  blur_valid,
	input  logic                  blur_stall,
	output blur_t                 blur,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [DIM_W-1:0] w_q, h_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [DIM_W-1:0] in_row_q;
	logic [ROW_W-1:0] out_row_q;

	logic in_col_end, out_col_end, out_row_end, frame_in_done, primed;
	logic accept, take;
	ctl_t ctl_in;

	logic               v1_q, v2_q, v3_q, ov_q;
	logic               adv1, adv2, adv3, en1, en2, en3;
	logic [PIX_W-1:0]   px_s1;
	logic [COL_W-1:0]   col_s1;
	ctl_t               ctl_s1, ctl_s2;
	logic               fwd_s1;
	logic [2*PIX_W-1:0] rd_s1;
	logic [PIX_W-1:0]   last_up_q, last_mid_q;
	logic [PIX_W-1:0]   up_eff, mid_eff;

	logic [PIX_W-1:0] win_q [3][3];

	logic [SUM_W-1:0]  sum_c [3];
	logic [1:0]        rows_c, cols_c;
	logic [CNT_W-1:0]  n_c;
	logic [SUM_W-1:0]  sum_s3 [3];
	logic [CNT_W-1:0]  n_s3;
	logic [RCP_W-1:0]  recip_s3;
	logic              last_s3;
	logic [SUM_W:0]    x_c [3];
	logic [PROD_W-1:0] prod_c [3];
	blur_t             blur_q;

	// input side control
	assign in_col_end    = (DIM_W'(in_col_q) + DIM_W'(1)) >= w_q;
	assign out_col_end   = (DIM_W'(out_col_q) + DIM_W'(1)) >= w_q;
	assign out_row_end   = (DIM_W'(out_row_q) + DIM_W'(1)) >= h_q;
	assign frame_in_done = in_row_q >= h_q;
	assign primed        = (in_row_q >= DIM_W'(2)) ||
	                       ((in_row_q == DIM_W'(1)) && (in_col_q != '0));

	assign accept = pix_valid && !pix_stall;
	assign take   = accept && ((pix.op == OP_PIXEL) ? !frame_in_done : frame_in_done);

	always_comb begin
		ctl_in.do_out   = primed;
		ctl_in.top_ok   = out_row_q != '0;
		ctl_in.bot_ok   = !out_row_end;
		ctl_in.left_ok  = out_col_q != '0;
		ctl_in.right_ok = !out_col_end;
		ctl_in.last     = out_row_end && out_col_end;
	end

	// pipeline enables
	assign adv3 = v3_q && (!ov_q || !blur_stall);
	assign en3  = !v3_q || adv3;
	assign adv2 = v2_q && en3;
	assign en2  = !v2_q || adv2;
	assign adv1 = v1_q && en2;
	assign en1  = !v1_q || adv1;
	assign pix_stall = !en1;

	// registers and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= DIM_W'(MAX_WIDTH);
			h_q       <= DIM_W'(MAX_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  w_q <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
				REG_IMAGE_HEIGHT: h_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (ctl_in.do_out && ctl_in.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + DIM_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (ctl_in.do_out) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// stage 1: line RAM read, then write-back of the shifted column
	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1  <= line_mem[in_col_q];
			px_s1  <= (pix.op == OP_PIXEL) ? {pix.red_in, pix.green_in, pix.blue_in} : '0;
			col_s1 <= in_col_q;
			ctl_s1 <= ctl_in;
			fwd_s1 <= v1_q && (col_s1 == in_col_q);
		end
		if (adv1) begin
			line_mem[col_s1] <= {mid_eff, px_s1};
			last_up_q        <= mid_eff;
			last_mid_q       <= px_s1;
			ctl_s2           <= ctl_s1;
		end
	end

	assign up_eff  = fwd_s1 ? last_up_q  : rd_s1[2*PIX_W-1:PIX_W];
	assign mid_eff = fwd_s1 ? last_mid_q : rd_s1[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= '0;
		end else if (adv1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_eff;
			win_q[1][2] <= mid_eff;
			win_q[2][2] <= px_s1;
		end
	end

	// stage 2: masked window sums and divisor
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = '0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					if ((r != 0 || ctl_s2.top_ok) && (r != 2 || ctl_s2.bot_ok) &&
					    (c != 0 || ctl_s2.left_ok) && (c != 2 || ctl_s2.right_ok))
						sum_c[ch] = sum_c[ch] + SUM_W'(win_q[r][c][ch*CH_W +: CH_W]);
		end
		rows_c = 2'd1 + 2'(ctl_s2.top_ok) + 2'(ctl_s2.bot_ok);
		cols_c = 2'd1 + 2'(ctl_s2.left_ok) + 2'(ctl_s2.right_ok);
		n_c    = CNT_W'(rows_c) * CNT_W'(cols_c);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int ch = 0; ch < 3; ch++)
				sum_s3[ch] <= sum_c[ch];
			n_s3     <= n_c;
			recip_s3 <= recip(n_c);
			last_s3  <= ctl_s2.last;
		end
	end

	// stage 3: floor((2*sum + n) / (2n)) by reciprocal multiply
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			x_c[ch]    = {sum_s3[ch], 1'b0} + (SUM_W+1)'(n_s3);
			prod_c[ch] = PROD_W'(x_c[ch]) * PROD_W'(recip_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			blur_q.red_out    <= prod_c[2][RCP_SHIFT +: CH_W];
			blur_q.green_out  <= prod_c[1][RCP_SHIFT +: CH_W];
			blur_q.blue_out   <= prod_c[0][RCP_SHIFT +: CH_W];
			blur_q.frame_last <= last_s3;
		end
	end

	// valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (take)
				v1_q <= 1'b1;
			else if (adv1)
				v1_q <= 1'b0;
			if (adv1)
				v2_q <= ctl_s1.do_out;
			else if (adv2)
				v2_q <= 1'b0;
			if (adv2)
				v3_q <= 1'b1;
			else if (adv3)
				v3_q <= 1'b0;
			if (adv3)
				ov_q <= 1'b1;
			else if (!blur_stall)
				ov_q <= 1'b0;
		end
	end

	assign blur_valid = ov_q;
	assign blur       = blur_q;

	`BB_ASSERT_NOW(a_window_safe, adv1, (!v2_q || adv2), "window shifted under held sum")
	`BB_ASSERT_NOW(a_divisor_known, v3_q, (recip_s3 != '0), "no reciprocal for divisor")
	`BB_ASSERT_NEXT(a_frame_restart, (take && ctl_in.do_out && ctl_in.last),
		(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0),
		"counters not cleared after last pixel")

endmodule

/* bench/testbench.sv */
// Self-checking testbench for box_blur_3x3_rgb: blur scoreboard, stream and config drivers, top.
module testbench;
	import bblur_pkg::*;

	class blur_scoreboard;
		logic [PIX_W-1:0] upper_row [MAX_WIDTH];
		logic [PIX_W-1:0] middle_row [MAX_WIDTH];
		logic [PIX_W-1:0] win [3][3];
		int unsigned width_reg;
		int unsigned height_reg;
		int unsigned col_in;
		int unsigned col_out;
		int unsigned row_out;
		int unsigned taken;
		blur_t expected_blur [$];
		int errors;
		int checked;
		int frames;
		int accepted;
		int settings;

		function new();
			width_reg = MAX_WIDTH;
			height_reg = MAX_HEIGHT;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (win[r, c]) win[r][c] = '0;
			errors = 0;
			checked = 0;
			frames = 0;
			accepted = 0;
			settings = 0;
			restart();
		endfunction

		function void restart();
			col_in = 0;
			col_out = 0;
			row_out = 0;
			taken = 0;
		endfunction

		function int unsigned span(int unsigned v, int unsigned cap);
			if (v == 0)
				return 1;
			return (v > cap) ? cap : v;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg = v;
				REG_IMAGE_HEIGHT: height_reg = v;
				default: ;
			endcase
			settings++;
			restart();
		endfunction

		// one accepted input transaction; queues the blurred pixel it releases, if any
		function void take_pixel(pix_t item);
			int unsigned w, h, col, n, sr, sg, sb;
			logic [PIX_W-1:0] px, up, mid;
			bit last;
			blur_t b;
			accepted++;
			w = span(width_reg, MAX_WIDTH);
			h = span(height_reg, MAX_HEIGHT);
			if (item.op == OP_PIXEL) begin
				if (taken >= w * h)
					return;
				px = {item.red_in, item.green_in, item.blue_in};
			end else begin
				if (taken < w * h)
					return;
				px = '0;
			end
			col = col_in;
			up = upper_row[col];
			mid = middle_row[col];
			upper_row[col] = mid;
			middle_row[col] = px;
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = up;
			win[1][2] = mid;
			win[2][2] = px;
			col_in++;
			if (col_in >= w)
				col_in = 0;
			taken++;
			if (taken - 1 < w + 1)
				return;

			n = 0;
			sr = 0;
			sg = 0;
			sb = 0;
			for (int r = 0; r < 3; r++) begin
				if ((r == 0 && row_out == 0) || (r == 2 && row_out + 1 >= h))
					continue;
				for (int c = 0; c < 3; c++) begin
					if ((c == 0 && col_out == 0) || (c == 2 && col_out + 1 >= w))
						continue;
					sr += win[r][c][23:16];
					sg += win[r][c][15:8];
					sb += win[r][c][7:0];
					n++;
				end
			end
			b.red_out = CH_W'((2 * sr + n) / (2 * n));
			b.green_out = CH_W'((2 * sg + n) / (2 * n));
			b.blue_out = CH_W'((2 * sb + n) / (2 * n));
			last = (row_out + 1 >= h) && (col_out + 1 >= w);
			b.frame_last = last;
			expected_blur.push_back(b);

			if (last) begin
				restart();
				frames++;
			end else begin
				col_out++;
				if (col_out >= w) begin
					col_out = 0;
					row_out++;
				end
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_blur(blur_t got);
			blur_t want;
			if (expected_blur.size() == 0) begin
				$display("%0t: blurred pixel expected none got %h", $time, got);
				errors++;
				return;
			end
			want = expected_blur.pop_front();
			checked++;
			compare_field("red_out", want.red_out, got.red_out);
			compare_field("green_out", want.green_out, got.green_out);
			compare_field("blue_out", want.blue_out, got.blue_out);
			compare_field("frame_last", want.frame_last, got.frame_last);
		endfunction
	endclass

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_BEAT,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic blur_valid;
	logic blur_stall = 1'b0;
	blur_t blur;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	blur_scoreboard sb;
	int burst_left = 0;
	bit fast_lane = 1'b0;
	int items_sent = 0;

	box_blur_3x3_rgb dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.blur_valid(blur_valid),
		.blur_stall(blur_stall),
		.blur(blur),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("testbench: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (pix_valid && !pix_stall)
				sb.take_pixel(pix);
			if (blur_valid && !blur_stall)
				sb.check_blur(blur);
		end
	end

	initial begin : stall_pattern
		stall_mode_t mode;
		int left, tick, period;
		mode = STALL_NONE;
		left = 0;
		tick = 0;
		period = 2;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(40, 300);
				period = $urandom_range(2, 7);
			end
			left--;
			tick++;
			case (mode)
				STALL_NONE:  blur_stall <= 1'b0;
				STALL_LIGHT: blur_stall <= ($urandom_range(0, 3) == 0);
				STALL_BEAT:  blur_stall <= (tick % period) == 0;
				STALL_HEAVY: blur_stall <= ($urandom_range(0, 9) < 7);
				default:     blur_stall <= 1'b0;
			endcase
		end
	end

	function automatic logic [CH_W-1:0] shade();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic pix_t fresh_pixel(op_t op);
		pix_t p;
		p.op = op;
		p.red_in = shade();
		p.green_in = shade();
		p.blue_in = shade();
		return p;
	endfunction

	function automatic int fit(int raw, int cap);
		if (raw == 0)
			return 1;
		return (raw > cap) ? cap : raw;
	endfunction

	task automatic push(input pix_t item);
		int gap;
		gap = 0;
		if (!fast_lane) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix <= item;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	// drop valid, let every pending blurred pixel come out, then let the pipe empty
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_blur.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input int v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// pixels then drains; noise items land where the block must ignore them
	task automatic stream_frame(input int w, input int h, input bit noisy, input int cut);
		int k;
		for (k = 0; k < w * h; k++) begin
			if (k == cut)
				return;
			if (noisy && $urandom_range(0, 24) == 0)
				push(fresh_pixel(OP_DRAIN));
			push(fresh_pixel(OP_PIXEL));
			items_sent++;
		end
		for (k = 0; k <= w; k++) begin
			if (noisy && $urandom_range(0, 24) == 0)
				push(fresh_pixel(OP_PIXEL));
			push(fresh_pixel(OP_DRAIN));
			items_sent++;
		end
		if (noisy && $urandom_range(0, 3) == 0)
			push(fresh_pixel(OP_DRAIN));
	endtask

	initial begin : stimulus
		pix_t item;
		int w_raw, h_raw, w_eff, h_eff, cut, k;
		bit must_write;
		sb = new();
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		w_eff = 1;
		h_eff = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame: corners, edges, center; early drain and late pixel are dropped
		write_cfg(REG_IMAGE_WIDTH, 3);
		write_cfg(REG_IMAGE_HEIGHT, 3);
		for (k = 0; k < 9; k++) begin
			item.op = OP_PIXEL;
			item.red_in = (k % 2) ? 8'hFF : 8'h00;
			item.green_in = (k % 3 == 0) ? 8'hFF : 8'h01;
			item.blue_in = CH_W'(k * 29 + 7);
			push(item);
			if (k == 2)
				push(fresh_pixel(OP_DRAIN));
		end
		push(fresh_pixel(OP_PIXEL));
		repeat (4) push(fresh_pixel(OP_DRAIN));
		push(fresh_pixel(OP_DRAIN));
		settle();

		// single pixel frame
		write_cfg(REG_IMAGE_WIDTH, 1);
		write_cfg(REG_IMAGE_HEIGHT, 1);
		push(fresh_pixel(OP_PIXEL));
		repeat (2) push(fresh_pixel(OP_DRAIN));
		settle();

		// frame cut short, next register write restarts it
		write_cfg(REG_IMAGE_WIDTH, 4);
		write_cfg(REG_IMAGE_HEIGHT, 2);
		repeat (6) push(fresh_pixel(OP_PIXEL));
		settle();

		// out-of-range sizes clamp to full size: cut just after the first row wraps
		fast_lane = 1'b1;
		write_cfg(REG_IMAGE_WIDTH, 2047);
		write_cfg(REG_IMAGE_HEIGHT, 2047);
		stream_frame(MAX_WIDTH, MAX_HEIGHT, 1'b0, MAX_WIDTH + 4);
		settle();

		must_write = 1'b1;
		while (items_sent < 1250) begin
			k = $urandom_range(0, 19);
			w_raw = (k == 0) ? 0 : (k == 1) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			k = $urandom_range(0, 19);
			h_raw = (k == 0) ? 0 : (k == 1) ? $urandom_range(11, 24) : $urandom_range(1, 10);
			if (must_write || $urandom_range(0, 3) != 0) begin
				settle();
				write_cfg(REG_IMAGE_WIDTH, w_raw);
				w_eff = fit(w_raw, MAX_WIDTH);
				if (must_write || $urandom_range(0, 2) != 0) begin
					write_cfg(REG_IMAGE_HEIGHT, h_raw);
					h_eff = fit(h_raw, MAX_HEIGHT);
				end
			end
			fast_lane = ($urandom_range(0, 3) == 0);
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w_eff * h_eff - 1) : -1;
			stream_frame(w_eff, h_eff, $urandom_range(0, 2) == 0, cut);
			must_write = (cut >= 0);
		end
		settle();

		if (sb.expected_blur.size() != 0)
			$display("%0t: %0d blurred pixels never arrived", $time, sb.expected_blur.size());
		$display("summary: %0d stream transactions, %0d blurred pixels checked, %0d frames done",
			sb.accepted, sb.checked, sb.frames);
		$display("summary: %0d register writes, sizes 1 to %0d, clamped and zero sizes included",
			sb.settings, MAX_WIDTH);
		if (sb.errors == 0 && sb.expected_blur.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* box_blur_3x3_rgb.f */
+incdir+sv
sv/bblur_pkg.sv
sv/box_blur_3x3_rgb.sv
bench/testbench.sv
